// File: design/dpq_pkg.sv
// ----------------------------------------------------------------------------
// dpq_pkg: shared types and constants for the drop pulse qualifier
// Detector phases, sequencer states, divider handshake types and fixed numeric constants.
// ----------------------------------------------------------------------------
package dpq_pkg;

  typedef enum logic [1:0] {
    PH_WAIT        = 2'd0,
    PH_CONFIRM     = 2'd1,
    PH_WAIT_REL    = 2'd2,
    PH_CONFIRM_REL = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_LOAD,
    SQ_SORT,
    SQ_PICK,
    SQ_DIV,
    SQ_OUT
  } seq_e;

  localparam logic [1:0] CFG_IDLE_LEVEL   = 2'd0;
  localparam logic [1:0] CFG_CONFIRM_US   = 2'd1;
  localparam logic [1:0] CFG_RELEASE_MS   = 2'd2;
  localparam logic [1:0] CFG_MIN_GAP_MS   = 2'd3;

  localparam logic [23:0] RATE_NUM = 24'd15360000;

  // Divider handshake between the sequencer and the divide unit.
  typedef struct packed {
    logic        start;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] quotient;
  } div_rsp_t;

endpackage

// File: design/dpq_divider.sv
// ----------------------------------------------------------------------------
// dpq_divider: restoring divider, one quotient bit per cycle
// Divides the fixed rate numerator by a 32-bit divisor.
// ----------------------------------------------------------------------------
module dpq_divider
  import dpq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [32:0] rem_q, rem_d;
  logic [23:0] quo_q, quo_d;
  logic [31:0] dsr_q, dsr_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], quo_q[23]};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = RATE_NUM;
      dsr_d  = req_i.divisor;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one numerator bit in, subtract when it fits
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quo_d = {quo_q[22:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[22:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: design/drip_pulse_qualifier_rate.sv
// ----------------------------------------------------------------------------
// drip_pulse_qualifier_rate: drop detector with median interval and rate
// Qualifies beam-sensor pulses into drops, keeps statistics, reports rate.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sensor sample per request: tdata = {time_us, time_ms,
//   beam_level}. m_axis returns one result per sample with all counters, the
//   median of the last MEDIAN_DEPTH intervals and the rate in drops/minute Q8.
//   The cfg port writes the idle level, confirm_time_us, release_time_ms and
//   minimum_gap_ms by index; write only while the block is idle.
// Sample sequence:
//   One sample at a time. A sample passes an accept step for the detector
//   update, a copy of the ring, the bubble-sort compare-swaps through the one
//   shared comparator and a closing step, a pick step, the bit-serial divider
//   (quotient bits and the done flag) and an output step. With fewer than two
//   drops or a zero divisor the divider is skipped.
// Reset:
//   All counters clear, narrowest width goes to all ones, phase to wait.
//   The interval ring is not cleared; only written entries are ever read.
// Stall:
//   The result waits in the output register until m_axis_tready; the block
//   accepts no new sample meanwhile.
// ----------------------------------------------------------------------------
module drip_pulse_qualifier_rate
  import dpq_pkg::*;
#(
  parameter int MEDIAN_DEPTH = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [19:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // beam_level[0], time_ms[32:1], time_us[64:33], zero fill
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // drop_counted[0], drop_total[32:1], recent_interval_ms[64:33],
  // median_interval_ms[96:65], rate_dpm_q8[120:97], spike_rejects[152:121],
  // close_rejects[184:153], pulses_measured[216:185],
  // narrowest_pulse_ms[248:217], widest_pulse_ms[280:249],
  // idle_sample_count[312:281], active_sample_count[344:313], zero fill
  output logic [351:0] m_axis_tdata
);

  localparam int IW = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
  localparam int FW = $clog2(MEDIAN_DEPTH + 1);

  // configuration
  logic        idle_lvl_q;
  logic [19:0] confirm_q;
  logic [13:0] release_q;
  logic [16:0] min_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_lvl_q <= 1'b0;
      confirm_q  <= 20'd600;
      release_q  <= 14'd25;
      min_gap_q  <= 17'd250;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDLE_LEVEL: idle_lvl_q <= cfg_data_i[0];
        CFG_CONFIRM_US: confirm_q  <= cfg_data_i;
        CFG_RELEASE_MS: release_q  <= cfg_data_i[13:0];
        CFG_MIN_GAP_MS: min_gap_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // detector state and statistics
  phase_e      phase_q, phase_d;
  seq_e        seq_q, seq_d;
  logic [31:0] edge_ms_q, edge_us_q, prev_ms_q, latest_q;
  logic [31:0] drops_q, short_q, gaprej_q, wsamp_q, minw_q, maxw_q;
  logic [31:0] idles_q, actives_q;
  logic [IW-1:0] wpos_q;
  logic [FW-1:0] fill_q;
  logic [31:0] ring_q [MEDIAN_DEPTH];
  logic [31:0] srt_q  [MEDIAN_DEPTH];
  logic        counted_q;
  logic [31:0] now_ms_q, med_q;
  logic [IW-1:0] i_q, j_q;
  logic [23:0] rate_q;

  logic        lv;
  logic [31:0] now_ms, now_us;
  logic        idle_s, accept;
  logic [31:0] width, iv;

  assign lv     = s_axis_tdata[0];
  assign now_ms = s_axis_tdata[32:1];
  assign now_us = s_axis_tdata[64:33];
  assign idle_s = (lv == idle_lvl_q);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign width  = now_ms - edge_ms_q;
  assign iv     = edge_ms_q - prev_ms_q;
  assign s_axis_tready = (seq_q == SQ_IDLE);

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [31:0] gap, base, eff;

  assign gap  = now_ms_q - prev_ms_q;
  assign base = (med_q != 32'd0) ? med_q : latest_q;
  assign eff  = (base > gap) ? base : gap;

  dpq_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // shared compare unit: one bubble-sort compare-swap per cycle
  logic swap;
  assign swap = srt_q[j_q] > srt_q[j_q + IW'(1)];

  // next state of the sequencer
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SQ_IDLE: if (accept) seq_d = SQ_LOAD;
      SQ_LOAD: seq_d = SQ_SORT;
      SQ_SORT: begin
        if (MEDIAN_DEPTH < 2 || i_q == IW'(MEDIAN_DEPTH - 1)) seq_d = SQ_PICK;
      end
      SQ_PICK: seq_d = SQ_DIV;
      // skip the wait when no divide was started
      SQ_DIV: begin
        if (div_rsp.done || drops_q < 32'd2 || eff == 32'd0) seq_d = SQ_OUT;
      end
      SQ_OUT:  if (m_axis_tready) seq_d = SQ_IDLE;
      default: seq_d = SQ_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    div_req.start   = (seq_q == SQ_PICK) && (drops_q >= 32'd2) && (eff != 32'd0);
    div_req.divisor = eff;
    m_axis_tvalid   = (seq_q == SQ_OUT);
  end

  // detector phase transition
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_WAIT:        if (!idle_s) phase_d = PH_CONFIRM;
      PH_CONFIRM: begin
        if (idle_s) phase_d = PH_WAIT;
        else if (now_us - edge_us_q >= {12'd0, confirm_q}) phase_d = PH_WAIT_REL;
      end
      PH_WAIT_REL:    if (idle_s) phase_d = PH_CONFIRM_REL;
      PH_CONFIRM_REL: begin
        if (!idle_s) phase_d = PH_WAIT_REL;
        else if (width >= {18'd0, release_q}) phase_d = PH_WAIT;
      end
      default: phase_d = PH_WAIT;
    endcase
  end

  logic note_w, confirm_hit;
  assign note_w = (phase_q == PH_CONFIRM && idle_s) || (phase_q == PH_WAIT_REL && idle_s);
  assign confirm_hit = (phase_q == PH_CONFIRM) && !idle_s && (phase_d == PH_WAIT_REL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= SQ_IDLE;
      phase_q   <= PH_WAIT;
      edge_ms_q <= '0;
      edge_us_q <= '0;
      prev_ms_q <= '0;
      latest_q  <= '0;
      drops_q   <= '0;
      short_q   <= '0;
      gaprej_q  <= '0;
      wsamp_q   <= '0;
      minw_q    <= '1;
      maxw_q    <= '0;
      idles_q   <= '0;
      actives_q <= '0;
      wpos_q    <= '0;
      fill_q    <= '0;
      counted_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
    end else begin
      seq_q <= seq_d;
      if (accept) begin
        phase_q   <= phase_d;
        counted_q <= 1'b0;
        if (idle_s) idles_q <= idles_q + 32'd1;
        else actives_q <= actives_q + 32'd1;
        if (phase_q == PH_WAIT && !idle_s) begin
          edge_ms_q <= now_ms;
          edge_us_q <= now_us;
        end
        if (note_w) begin
          wsamp_q <= wsamp_q + 32'd1;
          if (width < minw_q) minw_q <= width;
          if (width > maxw_q) maxw_q <= width;
        end
        if (phase_q == PH_CONFIRM && idle_s) short_q <= short_q + 32'd1;
        if (phase_q == PH_WAIT_REL && idle_s) edge_ms_q <= now_ms;
        if (confirm_hit) begin
          if (drops_q != 32'd0 && iv < {15'd0, min_gap_q}) begin
            gaprej_q <= gaprej_q + 32'd1;
          end else begin
            counted_q <= 1'b1;
            drops_q   <= drops_q + 32'd1;
            prev_ms_q <= edge_ms_q;
            if (drops_q == 32'd0) begin
              latest_q <= '0;
            end else begin
              latest_q <= iv;
              wpos_q   <= (wpos_q == IW'(MEDIAN_DEPTH - 1)) ? '0 : wpos_q + IW'(1);
              if (fill_q != FW'(MEDIAN_DEPTH)) fill_q <= fill_q + FW'(1);
            end
          end
        end
      end
      if (seq_q == SQ_LOAD) begin
        i_q <= '0;
        j_q <= '0;
      end else if (seq_q == SQ_SORT) begin
        // bubble pass i compares j over 0 .. MEDIAN_DEPTH-2-i
        if (MEDIAN_DEPTH > 1) begin
          if (j_q >= IW'(MEDIAN_DEPTH - 2) - i_q) begin
            j_q <= '0;
            i_q <= i_q + IW'(1);
          end else begin
            j_q <= j_q + IW'(1);
          end
        end
      end
    end
  end

  // ring write, sort copy and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_ms_q <= now_ms;
      if (confirm_hit && drops_q != 32'd0 && !(iv < {15'd0, min_gap_q}))
        ring_q[wpos_q] <= iv;
    end
    if (seq_q == SQ_LOAD) begin
      // unfilled slots load as all ones so they sort to the top
      for (int k = 0; k < MEDIAN_DEPTH; k++)
        srt_q[k] <= (FW'(k) < fill_q) ? ring_q[k] : '1;
    end else if (seq_q == SQ_SORT && MEDIAN_DEPTH > 1 &&
                 !(j_q > IW'(MEDIAN_DEPTH - 2) - i_q) && swap) begin
      srt_q[j_q]          <= srt_q[j_q + IW'(1)];
      srt_q[j_q + IW'(1)] <= srt_q[j_q];
    end
    if (seq_q == SQ_PICK) begin
      rate_q <= '0;
    end
    if (seq_q == SQ_SORT && seq_d == SQ_PICK) begin
      med_q <= (fill_q == '0) ? 32'd0 : srt_q[IW'(fill_q >> 1)];
    end
    if (div_rsp.done) rate_q <= div_rsp.quotient;
  end

  assign m_axis_tdata = {7'd0, actives_q, idles_q, maxw_q, minw_q, wsamp_q, gaprej_q,
                         short_q, rate_q, med_q, latest_q, drops_q, counted_q};

  // a result leaves only from the output state
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> seq_q == SQ_OUT) else $error("result outside output state");
  // no new sample while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("sample taken during result");
  // fill never exceeds depth
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MEDIAN_DEPTH)) else $error("ring fill overflow");

endmodule
